// ----- hdl/dds_pkg.sv -----
// Shared types and constants for the delta-decode predicate scan.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package dds_pkg;

    // Channel and field widths
    localparam int WORD_W        = 64;
    localparam int MASK_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int SUM_W         = 32;
    localparam int MAX_USED_BITS = 4 * WORD_W;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LANES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_KIND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_HIGH   = 2'd3;

    // Predicate codes; the last one is unused and matches no lane
    localparam logic [1:0] CMP_EQ    = 2'd0;
    localparam logic [1:0] CMP_NE    = 2'd1;
    localparam logic [1:0] CMP_RANGE = 2'd2;
    localparam logic [1:0] CMP_NONE  = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic                         short_lanes;
        logic [1:0]                   compare_kind;
        logic signed [CFG_DATA_W-1:0] value_low;
        logic signed [CFG_DATA_W-1:0] value_high;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/dds_if.sv -----
// Valid/ready channel interfaces: delta blocks in, match masks out, config writes.
// Depends on dds_pkg for field widths.
`default_nettype none

interface dds_in_if
    import dds_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] delta_word_0;
    logic [WORD_W-1:0] delta_word_1;
    logic [WORD_W-1:0] delta_word_2;
    logic [WORD_W-1:0] delta_word_3;
    logic              column_start;
    logic              last_block;

    modport source (output valid, delta_word_0, delta_word_1, delta_word_2,
                    delta_word_3, column_start, last_block, input ready);
    modport sink   (input valid, delta_word_0, delta_word_1, delta_word_2,
                    delta_word_3, column_start, last_block, output ready);
endinterface

interface dds_out_if
    import dds_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] match_mask;
    logic              mask_last;

    modport source (output valid, match_mask, mask_last, input ready);
    modport sink   (input valid, match_mask, mask_last, output ready);
endinterface

interface dds_cfg_if
    import dds_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/dds_lane_scan.sv -----
// Prefix-sum decode and predicate compare for one lane width.
// Depends on dds_pkg (cfg_t, compare codes); instantiated by the top level.
`default_nettype none

module dds_lane_scan
    import dds_pkg::*;
#(
    parameter int LANE_W = 16,
    parameter int LANES  = 16
) (
    input  wire logic [LANES*LANE_W-1:0] deltas,
    input  wire logic [LANE_W-1:0]       carry_in,
    input  wire cfg_t                    cfg,
    output logic      [LANES-1:0]        hits,
    output logic      [LANE_W-1:0]       last_sum
);

    localparam int LEVELS = (LANES > 1) ? $clog2(LANES) : 1;

    logic [LANE_W-1:0]        pre [0:LEVELS][LANES];
    logic [LANE_W-1:0]        sums [LANES];
    logic signed [LANE_W-1:0] lo;
    logic signed [LANE_W-1:0] hi;

    // Truncate bounds to the lane width
    assign lo = cfg.value_low[LANE_W-1:0];
    assign hi = cfg.value_high[LANE_W-1:0];

    // Parallel prefix over the lane deltas, log2(LANES) adder levels
    genvar lv, k;
    generate
        for (k = 0; k < LANES; k++)
        begin : g_leaf
            assign pre[0][k] = deltas[k*LANE_W +: LANE_W];
        end
        for (lv = 0; lv < LEVELS; lv++)
        begin : g_level
            for (k = 0; k < LANES; k++)
            begin : g_node
                if (k >= (1 << lv))
                begin : g_add
                    assign pre[lv+1][k] = pre[lv][k] + pre[lv][k-(1 << lv)];
                end
                else
                begin : g_pass
                    assign pre[lv+1][k] = pre[lv][k];
                end
            end
        end
    endgenerate

    // Add the carried sum and test each decoded lane
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sums[i] = carry_in + pre[LEVELS][i];
            case (cfg.compare_kind)
                CMP_EQ:    hits[i] = ($signed(sums[i]) == lo);
                CMP_NE:    hits[i] = ($signed(sums[i]) != lo);
                CMP_RANGE: hits[i] = ($signed(sums[i]) >= lo) && ($signed(sums[i]) <= hi);
                default:   hits[i] = 1'b0;
            endcase
        end
    end

    assign last_sum = sums[LANES-1];

endmodule

`default_nettype wire

// ----- hdl/delta_decode_predicate_scan.sv -----
// Top level of the delta-decode predicate scan: channels, config registers, pipeline.
// Depends on dds_pkg, the interfaces in dds_if.sv and dds_lane_scan.
`default_nettype none

// Accepts one 256-bit delta block per clock and returns one match mask per block:
// the block is captured in an input register when it is accepted, then decoded and
// compared in a single pass into the result register, which drives its mask.
// Without a result stall the sustained rate of one block per cycle is set by the
// running-sum feedback, which is one carry add and a lane-width select each cycle; the
// log2(lanes)-level parallel prefix adder works on the registered block outside that
// loop. A stalled result holds the pipeline; the input side keeps taking blocks while
// the input register can advance. Configuration writes are taken at any time (ready
// is always high) but must only be issued while no block is in flight.
module delta_decode_predicate_scan
    import dds_pkg::*;
#(
    parameter int BLOCK_BITS = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dds_in_if.sink    blk,
    dds_out_if.source res,
    dds_cfg_if.sink   cfg
);

    localparam int USED_BITS = (BLOCK_BITS > MAX_USED_BITS) ? MAX_USED_BITS : BLOCK_BITS;
    localparam int LANES16   = USED_BITS / 16;
    localparam int LANES32   = USED_BITS / 32;

    cfg_t                  cfg_reg;
    logic                  s1_valid_reg;
    logic [MAX_USED_BITS-1:0] s1_block_reg;
    logic                  s1_start_reg;
    logic                  s1_last_reg;
    logic                  out_valid_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    logic                  out_last_reg;
    logic [SUM_W-1:0]      running_sum_reg;
    logic [SUM_W-1:0]      running_sum_next;
    logic [MASK_W-1:0]     mask_next;
    logic                  advance;
    logic [15:0]           carry16;
    logic [31:0]           carry32;
    logic [LANES16-1:0]    hits16;
    logic [LANES32-1:0]    hits32;
    logic [15:0]           last16;
    logic [31:0]           last32;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.wr_index)
                REG_SHORT_LANES:  cfg_reg.short_lanes  <= cfg.wr_data[0];
                REG_COMPARE_KIND: cfg_reg.compare_kind <= cfg.wr_data[1:0];
                REG_VALUE_LOW:    cfg_reg.value_low    <= cfg.wr_data;
                REG_VALUE_HIGH:   cfg_reg.value_high   <= cfg.wr_data;
                default:          ;
            endcase
        end
    end

    // Pipeline handshake: advance when the result register is free or drained
    assign advance   = !out_valid_reg || res.ready;
    assign blk.ready = !s1_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (blk.ready)
        begin
            s1_valid_reg <= blk.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk.ready && blk.valid)
        begin
            s1_block_reg <= {blk.delta_word_3, blk.delta_word_2,
                             blk.delta_word_1, blk.delta_word_0};
            s1_start_reg <= blk.column_start;
            s1_last_reg  <= blk.last_block;
        end
    end

    // Carry into the block, cleared at the start of a column
    assign carry16 = s1_start_reg ? 16'd0 : running_sum_reg[15:0];
    assign carry32 = s1_start_reg ? 32'd0 : running_sum_reg[31:0];

    dds_lane_scan #(
        .LANE_W (16),
        .LANES  (LANES16)
    ) u_scan16 (
        .deltas   (s1_block_reg[LANES16*16-1:0]),
        .carry_in (carry16),
        .cfg      (cfg_reg),
        .hits     (hits16),
        .last_sum (last16)
    );

    dds_lane_scan #(
        .LANE_W (32),
        .LANES  (LANES32)
    ) u_scan32 (
        .deltas   (s1_block_reg[LANES32*32-1:0]),
        .carry_in (carry32),
        .cfg      (cfg_reg),
        .hits     (hits32),
        .last_sum (last32)
    );

    // Select the active lane width
    always_comb
    begin
        mask_next = '0;
        if (cfg_reg.short_lanes)
        begin
            mask_next[LANES16-1:0] = hits16;
            running_sum_next       = {16'd0, last16};
        end
        else
        begin
            mask_next[LANES32-1:0] = hits32;
            running_sum_next       = last32;
        end
    end

    // Result register and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            running_sum_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                running_sum_reg <= running_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_mask_reg <= mask_next;
            out_last_reg <= s1_last_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.match_mask = out_mask_reg;
    assign res.mask_last  = out_last_reg;

`ifndef SYNTHESIS
    // Eight-lane mode never sets the upper mask half
    a_wide_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cfg_reg.short_lanes) |-> (out_mask_reg[15:8] == 8'd0))
        else $error("upper mask bits set in eight-lane mode");

    // The unused compare kind matches nothing
    a_kind3_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (cfg_reg.compare_kind == CMP_NONE)) |-> (out_mask_reg == '0))
        else $error("match bits set for unused compare kind");

    // A block in the input register moves to the result register when it advances
    a_block_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> out_valid_reg)
        else $error("input block lost on advance");

    // Short mode keeps the carried sum within 16 bits
    a_short_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && cfg_reg.short_lanes)
            |=> (running_sum_reg[31:16] == 16'd0))
        else $error("running sum exceeds lane width in short mode");
`endif

endmodule

`default_nettype wire
